// ===== src/pvd_pkg.sv =====
package pvd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned LEN_W   = 3;

    typedef enum logic [2:0] {
        KIND_LEAD,
        KIND_CONT,
        KIND_LAST,
        KIND_SINGLE,
        KIND_ERROR
    } t_kind;

    localparam logic [LEN_W-1:0] LEN_1       = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2       = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3       = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4       = 3'd4;
    localparam logic [LEN_W-1:0] LEN_5       = 3'd5;
    localparam logic [LEN_W-1:0] LEN_UNKNOWN = 3'd6;

    localparam logic [BYTE_W-1:0] MASK_LEN_2 = 8'h3F;
    localparam logic [BYTE_W-1:0] MASK_LEN_3 = 8'h1F;
    localparam logic [BYTE_W-1:0] MASK_LEN_4 = 8'h0F;

    typedef struct packed {
        t_kind             kind;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] data;
    } t_token;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      error;
        logic [LEN_W-1:0]          len;
    } t_result;

endpackage

// ===== src/pvd_fifo.sv =====
module pvd_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    n_wr;
    logic [AW-1:0]    n_rd;
    logic [CW-1:0]    n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

// ===== src/pvd_front.sv =====
module pvd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    output pvd_pkg::t_token      o_token
);

    import pvd_pkg::*;

    logic [LEN_W-1:0] r_remaining;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_remaining;
    logic [LEN_W-1:0] n_len;
    logic [LEN_W-1:0] form_len;

    always_comb begin
        casez (i_byte)
            8'b0???????: form_len = LEN_1;
            8'b10??????: form_len = LEN_2;
            8'b110?????: form_len = LEN_3;
            8'b1110????: form_len = LEN_4;
            8'b11110???: form_len = LEN_5;
            default:     form_len = LEN_UNKNOWN;
        endcase
    end

    always_comb begin
        n_remaining  = r_remaining;
        n_len        = r_len;
        o_token.data = i_byte;
        o_token.len  = r_len;
        o_token.kind = KIND_CONT;
        if (r_remaining == '0) begin
            o_token.len = form_len;
            case (form_len)
                LEN_1: begin
                    o_token.kind = KIND_SINGLE;
                end
                LEN_UNKNOWN: begin
                    o_token.kind = KIND_ERROR;
                    o_token.len  = LEN_1;
                end
                default: begin
                    o_token.kind = KIND_LEAD;
                    n_remaining  = form_len - LEN_W'(1);
                    n_len        = form_len;
                end
            endcase
        end else begin
            n_remaining = r_remaining - LEN_W'(1);
            if (r_remaining == LEN_W'(1)) begin
                o_token.kind = KIND_LAST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_len       <= '0;
        end else if (i_accept) begin
            r_remaining <= n_remaining;
            r_len       <= n_len;
        end
    end

endmodule

// ===== src/pvd_back.sv =====
module pvd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pvd_pkg::t_token  i_token,
    input  logic             i_token_empty,
    output logic             o_token_pop,
    input  logic             i_result_full,
    output logic             o_result_push,
    output pvd_pkg::t_result o_result
);

    import pvd_pkg::*;

    logic [VALUE_W-1:0] r_acc;
    logic [VALUE_W-1:0] n_acc;
    logic [VALUE_W-1:0] shifted;
    logic [VALUE_W-1:0] extended;
    logic [BYTE_W-1:0]  lead_bits;

    assign o_token_pop = !i_token_empty && !i_result_full;
    assign shifted     = {r_acc[VALUE_W-BYTE_W-1:0], i_token.data};

    always_comb begin
        case (i_token.len)
            LEN_2:   lead_bits = i_token.data & MASK_LEN_2;
            LEN_3:   lead_bits = i_token.data & MASK_LEN_3;
            LEN_4:   lead_bits = i_token.data & MASK_LEN_4;
            default: lead_bits = '0;
        endcase
    end

    always_comb begin
        case (i_token.len)
            LEN_2:   extended = {{18{shifted[13]}}, shifted[13:0]};
            LEN_3:   extended = {{11{shifted[20]}}, shifted[20:0]};
            LEN_4:   extended = {{4{shifted[27]}}, shifted[27:0]};
            default: extended = shifted;
        endcase
    end

    always_comb begin
        n_acc         = r_acc;
        o_result_push = 1'b0;
        o_result.value = '0;
        o_result.error = 1'b0;
        o_result.len   = i_token.len;
        case (i_token.kind)
            KIND_LEAD: begin
                n_acc = {{(VALUE_W-BYTE_W){1'b0}}, lead_bits};
            end
            KIND_CONT: begin
                n_acc = shifted;
            end
            KIND_LAST: begin
                n_acc          = shifted;
                o_result_push  = o_token_pop;
                o_result.value = extended;
            end
            KIND_SINGLE: begin
                o_result_push  = o_token_pop;
                o_result.value = {{(VALUE_W-7){i_token.data[6]}}, i_token.data[6:0]};
                o_result.len   = LEN_1;
            end
            KIND_ERROR: begin
                o_result_push  = o_token_pop;
                o_result.error = 1'b1;
                o_result.len   = LEN_1;
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (o_token_pop) begin
            r_acc <= n_acc;
        end
    end

endmodule

// ===== src/prefix_varint_decoder.sv =====
// decodes a byte stream in a leading-ones prefix code into signed 32-bit values; one byte
// is taken per cycle, without gaps while full is low; the result of an integer's last byte
// is registered in the token queue and then in the result queue before it is on the output
// ports, and a full result queue holds it back; the front classifier and the accumulator
// are joined by a token queue of TOKEN_DEPTH entries, and results wait in a queue of
// RESULT_DEPTH entries, so full rises only once both queues have filled behind a stalled
// consumer; a lead byte of 0xF8 to 0xFF gives an error item with value zero and length one
module prefix_varint_decoder #(
    parameter int unsigned TOKEN_DEPTH  = 2,
    parameter int unsigned RESULT_DEPTH = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    i_in_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [31:0]            o_value,
    output logic                          o_error,
    output logic [2:0]                    o_encoded_length
);

    import pvd_pkg::*;

    t_token  front_token;
    t_token  back_token;
    t_result back_result;
    t_result out_result;
    logic    in_accept;
    logic    token_empty;
    logic    token_pop;
    logic    result_full;
    logic    result_push;

    assign in_accept = push && !full;

    pvd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_in_byte),
        .o_token  (front_token)
    );

    pvd_fifo #(
        .WIDTH ($bits(t_token)),
        .DEPTH (TOKEN_DEPTH)
    ) u_token_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (front_token),
        .o_full  (full),
        .i_pop   (token_pop),
        .o_rdata (back_token),
        .o_empty (token_empty)
    );

    pvd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_token       (back_token),
        .i_token_empty (token_empty),
        .o_token_pop   (token_pop),
        .i_result_full (result_full),
        .o_result_push (result_push),
        .o_result      (back_result)
    );

    pvd_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RESULT_DEPTH)
    ) u_result_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (result_push),
        .i_wdata (back_result),
        .o_full  (result_full),
        .i_pop   (pop),
        .o_rdata (out_result),
        .o_empty (empty)
    );

    assign o_value          = out_result.value;
    assign o_error          = out_result.error;
    assign o_encoded_length = out_result.len;

    a_token_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !token_empty
    ) else $error("token queue empty after accepted item");

    a_error_shape: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error) |-> (o_value == '0 && o_encoded_length == LEN_1)
    ) else $error("error item with nonzero value or wrong length");

    a_length_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_encoded_length != '0 && o_encoded_length <= LEN_5)
    ) else $error("encoded length out of range");

    a_push_needs_pop: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        result_push |-> token_pop
    ) else $error("result pushed without consuming a token");

endmodule

// ===== tb/prefix_varint_decoder_tb.sv =====
`timescale 1ns / 1ps

module prefix_varint_decoder_tb;
    import pvd_pkg::*;

    class varint_expectations;
        t_result        awaited_ints[$];
        logic [7:0]     lead_byte;
        logic [2:0]     bytes_left;
        logic [31:0]    gathered;
        int unsigned    failures;

        function new();
            lead_byte  = '0;
            bytes_left = '0;
            gathered   = '0;
            failures   = 0;
        endfunction

        function logic [2:0] form_of(logic [7:0] b);
            casez (b)
                8'b0???????: return LEN_1;
                8'b10??????: return LEN_2;
                8'b110?????: return LEN_3;
                8'b1110????: return LEN_4;
                8'b11110???: return LEN_5;
                default:     return LEN_UNKNOWN;
            endcase
        endfunction

        function logic [31:0] sign_extend(logic [31:0] x, int unsigned bits);
            logic signed [31:0] t;
            t = x << (32 - bits);
            return t >>> (32 - bits);
        endfunction

        function void take_byte(logic [7:0] b);
            logic [2:0] n;
            t_result    r;
            if (bytes_left == '0) begin
                n = form_of(b);
                if (n == LEN_UNKNOWN) begin
                    r = '{value: '0, error: 1'b1, len: LEN_1};
                    awaited_ints.push_back(r);
                end else if (n == LEN_1) begin
                    r = '{value: sign_extend({24'd0, b}, 7), error: 1'b0, len: LEN_1};
                    awaited_ints.push_back(r);
                end else begin
                    lead_byte  = b;
                    bytes_left = n - 3'd1;
                    case (n)
                        LEN_2:   gathered = {24'd0, b & MASK_LEN_2};
                        LEN_3:   gathered = {24'd0, b & MASK_LEN_3};
                        LEN_4:   gathered = {24'd0, b & MASK_LEN_4};
                        default: gathered = '0;
                    endcase
                end
            end else begin
                gathered   = {gathered[23:0], b};
                bytes_left = bytes_left - 3'd1;
                if (bytes_left == '0) begin
                    n = form_of(lead_byte);
                    r.error = 1'b0;
                    r.len   = n;
                    r.value = (n == LEN_5) ? gathered : sign_extend(gathered, 7 * n);
                    awaited_ints.push_back(r);
                end
            end
        endfunction

        function void match_result(logic signed [31:0] value, logic error, logic [2:0] len);
            t_result r;
            if (awaited_ints.size() == 0) begin
                $error("unexpected result: value %0d error %0b length %0d", value, error, len);
                failures++;
                return;
            end
            r = awaited_ints.pop_front();
            if (value !== r.value) begin
                $error("value: expected %0d, got %0d", r.value, value);
                failures++;
            end
            if (error !== r.error) begin
                $error("error: expected %0b, got %0b", r.error, error);
                failures++;
            end
            if (len !== r.len) begin
                $error("encoded_length: expected %0d, got %0d", r.len, len);
                failures++;
            end
        endfunction

        function int unsigned pending();
            return awaited_ints.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [7:0]         i_in_byte = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [31:0] o_value;
    logic               o_error;
    logic [2:0]         o_encoded_length;

    varint_expectations sb;
    int unsigned        burst_left = 0;
    int unsigned        bytes_sent = 0;
    int unsigned        rx_cycle = 0;
    logic [7:0]         stall_bits = 8'b1011_0010;

    prefix_varint_decoder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_in_byte        (i_in_byte),
        .empty            (empty),
        .pop              (pop),
        .o_value          (o_value),
        .o_error          (o_error),
        .o_encoded_length (o_encoded_length)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver: full speed, coin flips, fixed pattern, long stalls
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.match_result(o_value, o_error, o_encoded_length);
        end
        rx_cycle <= rx_cycle + 1;
        stall_bits <= {stall_bits[6:0], stall_bits[7]};
        case ((rx_cycle / 64) % 4)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= stall_bits[0];
            default: pop <= ($urandom_range(0, 9) == 0);
        endcase
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        push      <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (full);
        sb.take_byte(b);
        bytes_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // one well-formed integer of random form and content, or an error lead byte of 0xF8 to 0xFF
    task automatic send_integer();
        int unsigned kind;
        int unsigned trail;
        logic [7:0]  lead;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1: begin lead = 8'($urandom_range(0, 8'h7F));            trail = 0; end
            2, 3: begin lead = 8'h80 | 8'($urandom_range(0, 8'h3F));    trail = 1; end
            4, 5: begin lead = 8'hC0 | 8'($urandom_range(0, 8'h1F));    trail = 2; end
            6, 7: begin lead = 8'hE0 | 8'($urandom_range(0, 8'h0F));    trail = 3; end
            8:    begin lead = 8'hF0 | 8'($urandom_range(0, 8'h07));    trail = 4; end
            default: begin lead = 8'($urandom_range(8'hF8, 8'hFF));     trail = 0; end
        endcase
        send_byte(lead);
        repeat (trail) send_byte(8'($urandom_range(0, 255)));
    endtask

    logic [7:0] directed_stream [0:24];
    bit         drained_mid;

    initial begin
        sb = new();
        directed_stream = '{
            8'h00, 8'h7F, 8'hF8, 8'hFF,
            8'h80, 8'h00,
            8'hBF, 8'hFF,
            8'hC0, 8'h00, 8'hFF,
            8'hEF, 8'hFF, 8'hFF, 8'hFF,
            8'hF0, 8'h80, 8'h00, 8'h00, 8'h00,
            8'hF7, 8'h7F, 8'hFF, 8'hFF, 8'hFF
        };
        drained_mid = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_stream[k]) send_byte(directed_stream[k]);
        drain();

        while (bytes_sent < 520) begin
            if (!drained_mid && bytes_sent >= 270) begin
                drain();
                drained_mid = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) begin
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_integer();
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("prefix_varint_decoder_tb passed");
        end else begin
            $display("prefix_varint_decoder_tb failed");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("prefix_varint_decoder_tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/pvd_pkg.sv
src/pvd_fifo.sv
src/pvd_front.sv
src/pvd_back.sv
src/prefix_varint_decoder.sv
tb/prefix_varint_decoder_tb.sv
